FILE: src/rld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder package
// Shared constants, byte codes and the command format that is passed from
// the parser to the beat generator.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned LANE_BYTES   = 8;
    localparam int unsigned MAX_RESULTS  = 32;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam int unsigned Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned LANE_CLAMP = (LANE_BYTES < 1) ? 1 :
                                         ((LANE_BYTES > 8) ? 8 : LANE_BYTES);

    localparam logic [2:0] HEADER_INIT = 3'(HEADER_BYTES);
    localparam logic [3:0] LANE_EFF    = 4'(LANE_CLAMP);
    localparam logic [3:0] LANE_MAX    = 4'd8;
    localparam logic [8:0] LONG_RUN    = 9'(MAX_RESULTS * LANE_CLAMP);

    localparam logic [7:0] CODE_END     = 8'd0;
    localparam logic [7:0] CODE_LITERAL = 8'd255;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_REPEAT  = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] len;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: src/rld_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder channel interfaces
// The compressed byte input channel and the expanded beat output channel.
// ----------------------------------------------------------------------------
interface rld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rld_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        beat_last;
    logic        frame_end;

    modport source (output valid, output out_data, output out_count,
                    output beat_last, output frame_end, input ready);
    modport sink   (input valid, input out_data, input out_count,
                    input beat_last, input frame_end, output ready);
endinterface

FILE: src/byte_run_length_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder
// Expands a byte-wise run-length coded stream into packed beats of up to
// eight bytes.
//
// The stream channel takes one compressed byte per transaction; the beats
// channel gives one packed beat per transaction, byte zero in the low bits.
// A parser accepts one byte per cycle while the queue is not full and posts a
// command for each byte that produces output; a two-entry command queue feeds
// the beat generator, which emits one beat per cycle through an output register while the receiver is ready.
// Header, code and length bytes produce no beat. A literal byte or an end
// code yields one beat, passed through the command queue and the output register.
// A repeat value yields ceil(count / lane) beats, up to 32, one per cycle while
// the receiver is ready; the parser keeps accepting until the queue fills, so
// input stalls while long repeat runs are emitted or the receiver holds off.
// Reset clears the parser to expect a frame header and empties the queue and
// the output register. When the receiver stalls, the output beat holds, the
// queue fills and the stream channel then deasserts ready.
// ----------------------------------------------------------------------------
module byte_run_length_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    rld_in_if.sink      stream,
    rld_out_if.source   beats
);

    rld_pkg::q_push_t q_push;
    rld_pkg::q_stat_t q_stat;
    rld_pkg::cmd_t    head;
    logic             pop;

    rld_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .q_stat (q_stat),
        .q_push (q_push)
    );

    rld_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    rld_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .beats  (beats)
    );

`ifndef NO_ASSERTIONS
    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        beats.valid && beats.frame_end |-> beats.out_count == 4'd0 && beats.beat_last)
        else $error("end beat carries data or is not marked last");

    a_data_beat: assert property (@(posedge clk) disable iff (!rst_n)
        beats.valid && !beats.frame_end |-> beats.out_count != 4'd0 &&
                                            beats.out_count <= 4'd8)
        else $error("data beat has an illegal byte count");

    a_repeat_fill: assert property (@(posedge clk) disable iff (!rst_n)
        beats.valid && beats.out_count > 4'd1 |->
            beats.out_data[15:8] == beats.out_data[7:0])
        else $error("repeat beat lanes differ");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("command queue reports full and empty together");
`endif

endmodule

FILE: src/rld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder parser
// Accepts compressed bytes, tracks the frame structure and issues one
// command for every byte that produces output.
// ----------------------------------------------------------------------------
module rld_front
(
    input  logic                clk,
    input  logic                rst_n,
    rld_in_if.sink              stream,
    input  rld_pkg::q_stat_t    q_stat,
    output rld_pkg::q_push_t    q_push
);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_CODE     = 3'd1;
    localparam logic [2:0] PH_LIT_LEN  = 3'd2;
    localparam logic [2:0] PH_LIT_DATA = 3'd3;
    localparam logic [2:0] PH_REP_VAL  = 3'd4;

    localparam bit HEADER_INIT_NZ = (rld_pkg::HEADER_INIT != 3'd0);
    localparam logic [2:0] PH_START = (HEADER_INIT_NZ) ? PH_HEADER : PH_CODE;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] header_left_reg, header_left_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] repeat_len_reg, repeat_len_next;
    logic       accept;
    logic [2:0] header_dec;
    logic [7:0] bytes_dec;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && !q_stat.full;
    assign header_dec   = header_left_reg - 3'd1;
    assign bytes_dec    = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        header_left_next  = header_left_reg;
        bytes_left_next   = bytes_left_reg;
        repeat_len_next   = repeat_len_reg;
        q_push.valid      = 1'b0;
        q_push.cmd.kind   = rld_pkg::KIND_LITERAL;
        q_push.cmd.len    = repeat_len_reg;
        q_push.cmd.value  = stream.in_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    header_left_next = header_dec;
                    if (header_dec == 3'd0)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE:
                begin
                    if (stream.in_byte == rld_pkg::CODE_END)
                    begin
                        q_push.valid     = 1'b1;
                        q_push.cmd.kind  = rld_pkg::KIND_END;
                        phase_next       = PH_START;
                        header_left_next = rld_pkg::HEADER_INIT;
                        bytes_left_next  = 8'd0;
                        repeat_len_next  = 8'd0;
                    end
                    else if (stream.in_byte == rld_pkg::CODE_LITERAL)
                    begin
                        phase_next = PH_LIT_LEN;
                    end
                    else
                    begin
                        repeat_len_next = stream.in_byte;
                        phase_next      = PH_REP_VAL;
                    end
                end
                PH_LIT_LEN:
                begin
                    bytes_left_next = stream.in_byte;
                    phase_next = (stream.in_byte != 8'd0) ? PH_LIT_DATA : PH_CODE;
                end
                PH_LIT_DATA:
                begin
                    q_push.valid    = 1'b1;
                    q_push.cmd.kind = rld_pkg::KIND_LITERAL;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_REP_VAL:
                begin
                    q_push.valid    = 1'b1;
                    q_push.cmd.kind = rld_pkg::KIND_REPEAT;
                    repeat_len_next = 8'd0;
                    phase_next      = PH_CODE;
                end
                default:
                begin
                    phase_next       = PH_START;
                    header_left_next = rld_pkg::HEADER_INIT;
                    bytes_left_next  = 8'd0;
                    repeat_len_next  = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            header_left_reg <= rld_pkg::HEADER_INIT;
            bytes_left_reg  <= 8'd0;
            repeat_len_reg  <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            header_left_reg <= header_left_next;
            bytes_left_reg  <= bytes_left_next;
            repeat_len_reg  <= repeat_len_next;
        end
    end

endmodule

FILE: src/rld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder command queue
// A short queue that decouples the parser from the beat generator.
// ----------------------------------------------------------------------------
module rld_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  rld_pkg::q_push_t    q_push,
    input  logic                pop,
    output rld_pkg::q_stat_t    q_stat,
    output rld_pkg::cmd_t       head
);

    localparam logic [rld_pkg::Q_PTR_W-1:0] PTR_LAST = rld_pkg::Q_PTR_W'(rld_pkg::QUEUE_DEPTH - 1);
    localparam logic [rld_pkg::Q_CNT_W-1:0] CNT_FULL = rld_pkg::Q_CNT_W'(rld_pkg::QUEUE_DEPTH);

    rld_pkg::cmd_t mem [rld_pkg::QUEUE_DEPTH];

    logic [rld_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rld_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rld_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = q_push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/rld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder beat generator
// Executes queued commands, emitting one output beat per cycle into a
// registered output stage while that stage is free or being taken.
// ----------------------------------------------------------------------------
module rld_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rld_pkg::q_stat_t    q_stat,
    input  rld_pkg::cmd_t       head,
    output logic                pop,
    rld_out_if.source           beats
);

    logic        busy_reg, busy_next;
    logic [7:0]  left_reg, left_next;
    logic [3:0]  lane_reg, lane_next;
    logic [7:0]  value_reg, value_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [3:0]  out_count_reg, out_count_next;
    logic        last_reg, last_next;
    logic        fend_reg, fend_next;

    logic        slot_free;
    logic        emit;
    logic [1:0]  cur_kind;
    logic [7:0]  cur_left;
    logic [3:0]  cur_lane;
    logic [7:0]  cur_value;
    logic [3:0]  cnt;
    logic [7:0]  rem;
    logic [63:0] rep_data;

    assign slot_free = !out_valid_reg || beats.ready;
    assign emit      = slot_free && (busy_reg || !q_stat.empty);
    assign pop       = slot_free && !busy_reg && !q_stat.empty;

    assign cur_kind  = busy_reg ? rld_pkg::KIND_REPEAT : head.kind;
    assign cur_left  = busy_reg ? left_reg : head.len;
    assign cur_value = busy_reg ? value_reg : head.value;
    assign cur_lane  = busy_reg ? lane_reg :
                       (({1'b0, head.len} > rld_pkg::LONG_RUN) ? rld_pkg::LANE_MAX
                                                                : rld_pkg::LANE_EFF);
    assign cnt       = (cur_left < {4'd0, cur_lane}) ? cur_left[3:0] : cur_lane;
    assign rem       = cur_left - {4'd0, cnt};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rep_data[8*i +: 8] = (4'(i) < cnt) ? cur_value : 8'd0;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        left_next      = left_reg;
        lane_next      = lane_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !beats.ready;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        last_next      = last_reg;
        fend_next      = fend_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            case (cur_kind)
                rld_pkg::KIND_LITERAL:
                begin
                    out_data_next  = {56'd0, cur_value};
                    out_count_next = 4'd1;
                    last_next      = 1'b1;
                    fend_next      = 1'b0;
                end
                rld_pkg::KIND_REPEAT:
                begin
                    out_data_next  = rep_data;
                    out_count_next = cnt;
                    last_next      = (rem == 8'd0);
                    fend_next      = 1'b0;
                    busy_next      = (rem != 8'd0);
                    left_next      = rem;
                    lane_next      = cur_lane;
                    value_next     = cur_value;
                end
                default:
                begin
                    out_data_next  = 64'd0;
                    out_count_next = 4'd0;
                    last_next      = 1'b1;
                    fend_next      = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg      <= left_next;
        lane_reg      <= lane_next;
        value_reg     <= value_next;
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        last_reg      <= last_next;
        fend_reg      <= fend_next;
    end

    assign beats.valid     = out_valid_reg;
    assign beats.out_data  = out_data_reg;
    assign beats.out_count = out_count_reg;
    assign beats.beat_last = last_reg;
    assign beats.frame_end = fend_reg;

endmodule

FILE: tb/rld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder scoreboard
// Watches the stream and beats channels. Each accepted stream byte is run
// through a parser that tracks the frame and run state of the decoder. The
// beats it predicts are queued. Each accepted beat is compared field by
// field with the oldest queued beat. Failures and outstanding beats are
// counted for the testbench top.
// ----------------------------------------------------------------------------
module rld_checker
(
    input  logic        clk,
    input  logic        rst_n,
    rld_in_if           stream,
    rld_out_if          beats,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned bytes_seen,
    output int unsigned beats_seen,
    output int unsigned frames_seen
);

    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_CODE     = 3'd1;
    localparam logic [2:0] ST_LIT_LEN  = 3'd2;
    localparam logic [2:0] ST_LIT_DATA = 3'd3;
    localparam logic [2:0] ST_REP_VAL  = 3'd4;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        fend;
    } beat_t;

    beat_t        beat_q[$];
    logic [2:0]   state;
    logic [2:0]   hdr_left;
    logic [7:0]   lit_left;
    logic [7:0]   rep_count;

    task automatic restart_frame();
        begin
            hdr_left  = rld_pkg::HEADER_INIT;
            state     = (hdr_left != 3'd0) ? ST_HEADER : ST_CODE;
            lit_left  = 8'd0;
            rep_count = 8'd0;
        end
    endtask

    task automatic expand_byte(input logic [7:0] b);
        int unsigned lane;
        int unsigned left;
        int unsigned cnt;
        int unsigned produced;
        int unsigned i;
        beat_t       nb;
        begin
            nb = '0;
            case (state)
                ST_HEADER:
                begin
                    hdr_left = hdr_left - 3'd1;
                    if (hdr_left == 3'd0)
                        state = ST_CODE;
                end
                ST_CODE:
                begin
                    if (b == rld_pkg::CODE_END)
                    begin
                        nb.last = 1'b1;
                        nb.fend = 1'b1;
                        beat_q.push_back(nb);
                        restart_frame();
                    end
                    else if (b == rld_pkg::CODE_LITERAL)
                    begin
                        state = ST_LIT_LEN;
                    end
                    else
                    begin
                        rep_count = b;
                        state     = ST_REP_VAL;
                    end
                end
                ST_LIT_LEN:
                begin
                    lit_left = b;
                    state    = (b != 8'd0) ? ST_LIT_DATA : ST_CODE;
                end
                ST_LIT_DATA:
                begin
                    nb.data[7:0] = b;
                    nb.count     = 4'd1;
                    nb.last      = 1'b1;
                    beat_q.push_back(nb);
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 8'd0)
                        state = ST_CODE;
                end
                ST_REP_VAL:
                begin
                    lane     = rld_pkg::LANE_CLAMP;
                    left     = rep_count;
                    produced = 0;
                    if ((left + lane - 1) / lane > rld_pkg::MAX_RESULTS)
                        lane = 8;
                    while (left > 0 && produced < rld_pkg::MAX_RESULTS)
                    begin
                        cnt     = (left < lane) ? left : lane;
                        nb      = '0;
                        for (i = 0; i < cnt; i++)
                            nb.data[8*i +: 8] = b;
                        left    -= cnt;
                        nb.count = 4'(cnt);
                        nb.last  = (left == 0);
                        beat_q.push_back(nb);
                        produced++;
                    end
                    rep_count = 8'd0;
                    state     = ST_CODE;
                end
                default:
                begin
                    restart_frame();
                end
            endcase
        end
    endtask

    task automatic compare_beat();
        beat_t exp_beat;
        begin
            if (beat_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected beat data=%h count=%0d last=%0b end=%0b",
                         $time, beats.out_data, beats.out_count,
                         beats.beat_last, beats.frame_end);
            end
            else
            begin
                exp_beat = beat_q.pop_front();
                if (beats.out_data !== exp_beat.data)
                begin
                    fail_count++;
                    $display("%0t: out_data expected %h actual %h",
                             $time, exp_beat.data, beats.out_data);
                end
                if (beats.out_count !== exp_beat.count)
                begin
                    fail_count++;
                    $display("%0t: out_count expected %0d actual %0d",
                             $time, exp_beat.count, beats.out_count);
                end
                if (beats.beat_last !== exp_beat.last)
                begin
                    fail_count++;
                    $display("%0t: beat_last expected %0b actual %0b",
                             $time, exp_beat.last, beats.beat_last);
                end
                if (beats.frame_end !== exp_beat.fend)
                begin
                    fail_count++;
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, exp_beat.fend, beats.frame_end);
                end
                if (exp_beat.fend)
                    frames_seen++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_q.delete();
            restart_frame();
            fail_count  = 0;
            pending     = 0;
            bytes_seen  = 0;
            beats_seen  = 0;
            frames_seen = 0;
        end
        else
        begin
            if (beats.valid === 1'b1 && beats.ready === 1'b1)
            begin
                beats_seen++;
                compare_beat();
            end
            if (stream.valid === 1'b1 && stream.ready === 1'b1)
            begin
                bytes_seen++;
                expand_byte(stream.in_byte);
            end
            pending = beat_q.size();
        end
    end

endmodule

FILE: tb/tb_byte_run_length_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length decoder testbench
// Feeds a short directed frame of edge cases followed by random frames of
// literal, repeat and end runs, mixed with stray bytes. Both channels idle
// at random, except for a stretch with no idling. The receiver also holds
// off once for a long time so that the decoder backs up and stalls its
// input. Checking is done by the scoreboard beside the decoder.
// ----------------------------------------------------------------------------
module tb_byte_run_length_decoder;

    localparam int unsigned RANDOM_BYTES = 80;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        no_gaps;
    logic        hold_go;
    logic [7:0]  stream_bytes[$];
    int unsigned directed_len;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned bytes_seen;
    int unsigned beats_seen;
    int unsigned frames_seen;

    rld_in_if  stream_ch ();
    rld_out_if beat_ch ();

    byte_run_length_decoder dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .beats  (beat_ch)
    );

    rld_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_ch),
        .beats       (beat_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .bytes_seen  (bytes_seen),
        .beats_seen  (beats_seen),
        .frames_seen (frames_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("%0t: timed out with %0d beats outstanding", $time, pending);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic add_random_frame();
        int unsigned runs;
        int unsigned len;
        int unsigned r;
        int unsigned k;
        begin
            for (k = 0; k < rld_pkg::HEADER_BYTES; k++)
                stream_bytes.push_back(8'($urandom));
            runs = $urandom_range(1, 4);
            for (r = 0; r < runs; r++)
            begin
                if ($urandom_range(1) == 0)
                begin
                    len = $urandom_range(0, 5);
                    stream_bytes.push_back(rld_pkg::CODE_LITERAL);
                    stream_bytes.push_back(8'(len));
                    for (k = 0; k < len; k++)
                        stream_bytes.push_back(8'($urandom));
                end
                else
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(1, 254)
                                                   : $urandom_range(1, 20);
                    stream_bytes.push_back(8'(len));
                    stream_bytes.push_back(8'($urandom));
                end
            end
            stream_bytes.push_back(rld_pkg::CODE_END);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        begin
            @(negedge clk);
            while (!no_gaps && $urandom_range(99) < 11)
            begin
                stream_ch.valid = 1'b0;
                @(negedge clk);
            end
            stream_ch.valid   = 1'b1;
            stream_ch.in_byte = b;
            @(posedge clk);
            while (stream_ch.ready !== 1'b1)
                @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        int unsigned hold_left;
        logic        hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        beat_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                beat_ch.ready = 1'b0;
            end
            else
            begin
                beat_ch.ready = no_gaps || ($urandom_range(99) >= 11);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned idx;
        int unsigned n;
        rst_n             = 1'b0;
        no_gaps           = 1'b0;
        hold_go           = 1'b0;
        stream_ch.valid   = 1'b0;
        stream_ch.in_byte = 8'd0;

        // Header with extreme bytes, empty literal, literal with extremes,
        // shortest and longest repeats and repeats either side of one lane.
        stream_bytes = {8'h00, 8'hFF, 8'h5A, 8'hA5,
                        rld_pkg::CODE_LITERAL, 8'd0,
                        rld_pkg::CODE_LITERAL, 8'd3, 8'h00, 8'hFF, 8'h81,
                        8'd1, 8'h00,
                        8'd254, 8'hFF,
                        8'd8, 8'h3C,
                        8'd9, 8'hC3,
                        rld_pkg::CODE_END};
        directed_len = stream_bytes.size();
        while (stream_bytes.size() < directed_len + RANDOM_BYTES)
        begin
            if ($urandom_range(99) < 85)
            begin
                add_random_frame();
            end
            else
            begin
                n = $urandom_range(1, 5);
                repeat (n) stream_bytes.push_back(8'($urandom));
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (idx = 0; idx < stream_bytes.size(); idx++)
        begin
            hold_go = (idx >= directed_len + 30);
            no_gaps = (idx >= directed_len + 50) && (idx < directed_len + 80);
            send_byte(stream_bytes[idx]);
        end
        @(negedge clk);
        stream_ch.valid = 1'b0;
        no_gaps         = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d stream bytes, %0d beats and %0d closed frames,",
                 bytes_seen, beats_seen, frames_seen);
        $display("including a %0d-cycle receiver stall and a gap-free stretch.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d beats outstanding", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
